/* design/dda_pkg.sv */
`timescale 1ns / 1ps

package dda_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 64;

  // Field widths
  localparam int COORD_W = 6;
  localparam int ADDR_W  = 12;
  localparam int COLOR_W = 32;

  // Remainder of the error term spans [-2L, 4L), with L below 2**COORD_W
  localparam int REM_W   = COORD_W + 3;
  localparam int DELTA_W = COORD_W + 1;

  // Saturation limits for incoming endpoints
  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COLOR_W-1:0] color_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // Control from the sequencer to each axis unit
  typedef struct packed {
    logic init;
    logic step;
  } axis_ctrl_t;

endpackage

/* design/dda_cmd_if.sv */
`timescale 1ns / 1ps

interface dda_cmd_if import dda_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t end_x;
  coord_t start_y;
  coord_t end_y;
  color_t pixel_color;

  modport source (
    output valid, start_x, end_x, start_y, end_y, pixel_color,
    input  ready
  );

  modport sink (
    input  valid, start_x, end_x, start_y, end_y, pixel_color,
    output ready
  );
endinterface

/* design/dda_pix_if.sv */
`timescale 1ns / 1ps

interface dda_pix_if import dda_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  addr_t  pixel_address;
  color_t write_color;
  logic   last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_address, write_color, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_address, write_color, last_pixel,
    output ready
  );
endinterface

/* design/dda_line_pixel_generator.sv */
`timescale 1ns / 1ps

// Channel   Port     Dir  Beat
// command   in_cmd   in   start_x, end_x, start_y, end_y, pixel_color
// pixel     out_pix  out  pixel_x, pixel_y, pixel_address, write_color, last_pixel
//
// A line of length L = max(|dx|, |dy|) is walked by the per-axis error step
// units: the command is taken in idle, then one pixel beat per cycle while
// out_pix.ready is high. Commands are taken only while no line is being walked.
// rst_n (synchronous, active low) returns the sequencer to idle.
// A stalled pixel beat holds; the walk resumes when out_pix.ready returns.
module dda_line_pixel_generator import dda_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dda_cmd_if.sink   in_cmd,
  dda_pix_if.source out_pix
);

  seq_state_t state_r, state_nxt;
  coord_t     count_r, count_nxt;
  coord_t     len_r,   len_nxt;
  color_t     color_r, color_nxt;
  axis_ctrl_t ctrl;

  coord_t                    x0, x1, y0, y1;
  logic signed [DELTA_W-1:0] dx, dy;
  coord_t                    adx, ady, len;
  coord_t                    pos_x, pos_y;
  logic                      last;

  // Endpoint saturation and line length
  always_comb begin
    x0  = (in_cmd.start_x > X_MAX) ? X_MAX : in_cmd.start_x;
    x1  = (in_cmd.end_x   > X_MAX) ? X_MAX : in_cmd.end_x;
    y0  = (in_cmd.start_y > Y_MAX) ? Y_MAX : in_cmd.start_y;
    y1  = (in_cmd.end_y   > Y_MAX) ? Y_MAX : in_cmd.end_y;
    dx  = $signed({1'b0, x1}) - $signed({1'b0, x0});
    dy  = $signed({1'b0, y1}) - $signed({1'b0, y0});
    adx = dx[DELTA_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    ady = dy[DELTA_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
    len = (adx >= ady) ? adx : ady;
  end

  assign last = (count_r == len_r);

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    color_nxt     = color_r;
    ctrl          = '0;
    in_cmd.ready  = 1'b0;
    out_pix.valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_cmd.ready = 1'b1;
        if (in_cmd.valid) begin
          ctrl.init = 1'b1;
          count_nxt = '0;
          len_nxt   = len;
          color_nxt = in_cmd.pixel_color;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        out_pix.valid = 1'b1;
        if (out_pix.ready) begin
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            ctrl.step = 1'b1;
            count_nxt = count_r + COORD_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Line registers
  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    len_r   <= len_nxt;
    color_r <= color_nxt;
  end

  // Axis walkers
  dda_axis u_axis_x (
    .clk       (clk),
    .ctrl      (ctrl),
    .start_pos (x0),
    .delta     (dx),
    .len       (len),
    .pos       (pos_x)
  );

  dda_axis u_axis_y (
    .clk       (clk),
    .ctrl      (ctrl),
    .start_pos (y0),
    .delta     (dy),
    .len       (len),
    .pos       (pos_y)
  );

  // Pixel beat
  assign out_pix.pixel_x       = pos_x;
  assign out_pix.pixel_y       = pos_y;
  assign out_pix.pixel_address = ADDR_W'({{(ADDR_W-COORD_W){1'b0}}, pos_y}
                                         * ADDR_W'(SCREEN_WIDTH))
                                 + ADDR_W'(pos_x);
  assign out_pix.write_color   = color_r;
  assign out_pix.last_pixel    = last;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_cmd.ready |-> !out_pix.valid)
    else $error("command taken while a line is active");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid |-> (count_r <= len_r))
    else $error("pixel count ran past line length");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && out_pix.ready && last) |=> in_cmd.ready)
    else $error("not idle after last pixel");

  a_unit_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |=> ((pos_x == $past(pos_x)) || (pos_x == $past(pos_x) + COORD_W'(1))
                   || (pos_x == $past(pos_x) - COORD_W'(1))))
    else $error("x moved by more than one column");

endmodule

/* design/dda_axis.sv */
`timescale 1ns / 1ps

// One axis of the line walker. Keeps pos = start + floor(n / 2L) with
// n = 2*k*d + L, as a position and a remainder in [0, 2L). Each step adds
// 2d to the remainder and corrects once, since |2d| <= 2L.
module dda_axis import dda_pkg::*; (
  input  logic                      clk,
  input  axis_ctrl_t                ctrl,
  input  coord_t                    start_pos,
  input  logic signed [DELTA_W-1:0] delta,
  input  coord_t                    len,
  output coord_t                    pos
);

  coord_t                    pos_r,     pos_nxt;
  logic signed [REM_W-1:0]   rem_r,     rem_nxt;
  logic signed [REM_W-1:0]   two_len_r, two_len_nxt;
  logic signed [DELTA_W:0]   d2_r,      d2_nxt;
  logic signed [REM_W-1:0]   sum;

  // Per-axis add / compare / correct step
  always_comb begin
    sum         = rem_r + {{(REM_W-DELTA_W-1){d2_r[DELTA_W]}}, d2_r};
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    two_len_nxt = two_len_r;
    d2_nxt      = d2_r;
    if (ctrl.init) begin
      pos_nxt     = start_pos;
      rem_nxt     = $signed({3'b000, len});
      two_len_nxt = $signed({2'b00, len, 1'b0});
      d2_nxt      = $signed({delta, 1'b0});
    end else if (ctrl.step) begin
      if (sum >= two_len_r) begin
        rem_nxt = sum - two_len_r;
        pos_nxt = pos_r + COORD_W'(1);
      end else if (sum[REM_W-1]) begin
        rem_nxt = sum + two_len_r;
        pos_nxt = pos_r - COORD_W'(1);
      end else begin
        rem_nxt = sum;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    rem_r     <= rem_nxt;
    two_len_r <= two_len_nxt;
    d2_r      <= d2_nxt;
  end

  assign pos = pos_r;

endmodule

/* tb/sv/dda_line_pixel_generator_tb.sv */
`timescale 1ns / 1ps

module dda_line_pixel_generator_tb;
  import dda_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_LINES = 320;
  localparam int QUIET_TAIL   = 60;      // final lines run with no idling
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    coord_t sx;
    coord_t ex;
    coord_t sy;
    coord_t ey;
    color_t color;
  } line_cmd_t;

  typedef struct {
    coord_t x;
    coord_t y;
    addr_t  addr;
    color_t color;
    logic   last;
  } pixel_t;

  logic clk;
  logic rst_n;

  dda_cmd_if cmd_ch ();
  dda_pix_if pix_ch ();

  dda_line_pixel_generator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_ch),
    .out_pix (pix_ch)
  );

  line_cmd_t pending_lines[$];
  pixel_t    expected_pixels[$];
  int        total_lines;
  int        lines_taken;
  int        mismatch_count;
  int        cycle_count;
  int        cmd_gap;
  int        pix_gap;

  always #5 clk = ~clk;

  // Idling runs in stretches; none at all over the final lines
  function automatic bit idling_allowed();
    return (lines_taken < total_lines - QUIET_TAIL) && ((lines_taken / 25) % 3 != 2);
  endfunction

  function automatic coord_t saturate(coord_t c, coord_t lim);
    return (c > lim) ? lim : c;
  endfunction

  // Offset round(k*d/len), halves toward +inf: floor((2kd + len) / 2len)
  function automatic int rounded_offset(int k, int d, int len);
    int num;
    int den;
    num = 2 * k * d + len;
    den = 2 * len;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // Walk the line and queue every pixel write it should produce
  task automatic plot_line(line_cmd_t c);
    int     x0, x1, y0, y1, dx, dy, len, px, py;
    pixel_t p;
    x0 = saturate(c.sx, X_MAX);
    x1 = saturate(c.ex, X_MAX);
    y0 = saturate(c.sy, Y_MAX);
    y1 = saturate(c.ey, Y_MAX);
    dx = x1 - x0;
    dy = y1 - y0;
    len = (dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                     : (dy < 0 ? -dy : dy);
    for (int k = 0; k <= len; k++) begin
      px = x0;
      py = y0;
      if (len > 0) begin
        px = x0 + rounded_offset(k, dx, len);
        py = y0 + rounded_offset(k, dy, len);
      end
      p.x     = coord_t'(px);
      p.y     = coord_t'(py);
      p.addr  = addr_t'(py * SCREEN_WIDTH + px);
      p.color = c.color;
      p.last  = (k == len);
      expected_pixels.push_back(p);
    end
  endtask

  task automatic queue_line(int sx, int ex, int sy, int ey, color_t color);
    line_cmd_t c;
    c.sx = coord_t'(sx);
    c.ex = coord_t'(ex);
    c.sy = coord_t'(sy);
    c.ey = coord_t'(ey);
    c.color = color;
    pending_lines.push_back(c);
  endtask

  function automatic int clip_coord(int v);
    return (v < 0) ? 0 : (v > 63) ? 63 : v;
  endfunction

  // Command driver: a beat holds until taken, gaps only between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
      cmd_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        plot_line('{cmd_ch.start_x, cmd_ch.end_x, cmd_ch.start_y, cmd_ch.end_y,
                    cmd_ch.pixel_color});
        void'(pending_lines.pop_front());
        lines_taken++;
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (cmd_gap > 0) begin
          cmd_gap--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_lines.size() > 0) begin
          cmd_ch.valid       <= 1'b1;
          cmd_ch.start_x     <= pending_lines[0].sx;
          cmd_ch.end_x       <= pending_lines[0].ex;
          cmd_ch.start_y     <= pending_lines[0].sy;
          cmd_ch.end_y       <= pending_lines[0].ey;
          cmd_ch.pixel_color <= pending_lines[0].color;
          if (idling_allowed() && $urandom_range(0, 2) == 0)
            cmd_gap = $urandom_range(1, 6);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: check each beat, stall ready in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.ready <= 1'b0;
      pix_gap = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel beat at x=%0d y=%0d", pix_ch.pixel_x, pix_ch.pixel_y);
          mismatch_count++;
        end else begin
          if (pix_ch.pixel_x !== expected_pixels[0].x) begin
            $error("pixel_x: expected %0d, got %0d", expected_pixels[0].x, pix_ch.pixel_x);
            mismatch_count++;
          end
          if (pix_ch.pixel_y !== expected_pixels[0].y) begin
            $error("pixel_y: expected %0d, got %0d", expected_pixels[0].y, pix_ch.pixel_y);
            mismatch_count++;
          end
          if (pix_ch.pixel_address !== expected_pixels[0].addr) begin
            $error("pixel_address: expected %0d, got %0d",
                   expected_pixels[0].addr, pix_ch.pixel_address);
            mismatch_count++;
          end
          if (pix_ch.write_color !== expected_pixels[0].color) begin
            $error("write_color: expected %h, got %h",
                   expected_pixels[0].color, pix_ch.write_color);
            mismatch_count++;
          end
          if (pix_ch.last_pixel !== expected_pixels[0].last) begin
            $error("last_pixel: expected %0b, got %0b",
                   expected_pixels[0].last, pix_ch.last_pixel);
            mismatch_count++;
          end
          void'(expected_pixels.pop_front());
        end
      end
      if (pix_gap > 0) begin
        pix_gap--;
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= 1'b1;
        if (idling_allowed() && $urandom_range(0, 7) == 0)
          pix_gap = $urandom_range(1, 6);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int sx, sy, ex, ey, kind;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.start_x = '0;
    cmd_ch.end_x   = '0;
    cmd_ch.start_y = '0;
    cmd_ch.end_y   = '0;
    cmd_ch.pixel_color = '0;
    pix_ch.ready   = 1'b0;
    lines_taken    = 0;
    mismatch_count = 0;
    cycle_count    = 0;

    // Directed: zero-length lines, screen edges, octants, rounding ties
    queue_line(0, 0, 0, 0, 32'h0000_0000);
    queue_line(63, 63, 63, 63, 32'hFFFF_FFFF);
    queue_line(0, 63, 0, 0, 32'hAAAA_AAAA);
    queue_line(63, 0, 63, 63, 32'h5555_5555);
    queue_line(0, 0, 0, 63, 32'h0000_0001);
    queue_line(63, 63, 63, 0, 32'h8000_0000);
    queue_line(0, 63, 0, 63, 32'h1234_5678);
    queue_line(63, 0, 0, 63, 32'h9ABC_DEF0);
    queue_line(0, 63, 63, 0, 32'hFFFF_0000);
    queue_line(63, 0, 63, 0, 32'h0000_FFFF);
    queue_line(0, 1, 0, 2, 32'hDEAD_BEEF);   // positive half rounds up
    queue_line(1, 0, 0, 2, 32'hCAFE_F00D);   // negative half rounds toward +inf
    queue_line(0, 2, 5, 4, 32'h0F0F_0F0F);
    queue_line(10, 13, 20, 14, 32'hF0F0_F0F0);
    queue_line(40, 1, 7, 10, 32'h7FFF_FFFF);
    queue_line(5, 6, 9, 9, 32'h0000_0002);
    queue_line(30, 30, 30, 31, 32'h4000_0000);
    queue_line(21, 42, 63, 0, 32'h3333_3333);
    queue_line(0, 62, 1, 32, 32'hCCCC_CCCC);
    queue_line(17, 17, 45, 45, 32'h0101_0101);

    // Random: mix of long, short, straight, diagonal and single-point lines
    for (int i = 0; i < RANDOM_LINES; i++) begin
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      ex = $urandom_range(0, 63);
      ey = $urandom_range(0, 63);
      kind = $urandom_range(0, 9);
      case (kind)
        5, 6: begin
          ex = clip_coord(sx + $urandom_range(0, 8) - 4);
          ey = clip_coord(sy + $urandom_range(0, 8) - 4);
        end
        7: begin
          if ($urandom_range(0, 1)) ey = sy;
          else ex = sx;
        end
        8: begin
          ex = clip_coord(sx + (($urandom_range(0, 1)) ? (ey - sy) : (sy - ey)));
        end
        9: begin
          ex = sx;
          ey = sy;
        end
        default: ;
      endcase
      queue_line(sx, ex, sy, ey, $urandom());
    end
    total_lines = pending_lines.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (lines_taken < total_lines || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
